FILE: hdl/c2p_pkg.sv
// Shared types and constants for the cartesian-to-polar converter.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package c2p_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned FRAC_BITS = 24;
  // Datapath x/y: 17-bit magnitude after pre-rotation, CORDIC gain, Q24 fraction.
  localparam int unsigned XY_W      = 43;
  // Angle accumulator in Q24 radians; |z| stays below 2^27.
  localparam int unsigned Z_W       = 29;
  localparam int unsigned SQ_W      = 32;
  localparam int unsigned ROOT_W    = 16;
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned OUT_SHIFT = 11;
  localparam int unsigned ATAN_LEN  = 24;

  localparam logic signed [Z_W-1:0] PI_Q24 = 29'sd52707179;

  // atan(2^-i) in Q24 radians, rounded to nearest
  localparam logic signed [Z_W-1:0] ATAN_Q24 [ATAN_LEN] = '{
    29'sd13176795, 29'sd7778716, 29'sd4110060, 29'sd2086331,
    29'sd1047214,  29'sd524117,  29'sd262123,  29'sd131069,
    29'sd65536,    29'sd32768,   29'sd16384,   29'sd8192,
    29'sd4096,     29'sd2048,    29'sd1024,    29'sd512,
    29'sd256,      29'sd128,     29'sd64,      29'sd32,
    29'sd16,       29'sd8,       29'sd4,       29'sd2
  };

  // Payload carried from cell to cell
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        rem;
    logic [SQ_W-1:0]        root;
    logic                   origin;
  } c2p_stage_t;

endpackage

`default_nettype wire

FILE: hdl/c2p_prep.sv
// Entry stage: squares and sum for the root, pre-rotation into the right half plane.
// Depends on c2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2p_prep (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  output logic                                ready_o,
  input  wire logic signed [c2p_pkg::COORD_W-1:0] x_coord_i,
  input  wire logic signed [c2p_pkg::COORD_W-1:0] y_coord_i,
  output logic                                valid_o,
  input  wire logic                           ready_i,
  output c2p_pkg::c2p_stage_t                 stage_o
);
  import c2p_pkg::*;

  localparam int unsigned MAG_W = COORD_W + 1;
  localparam int unsigned PAD_W = XY_W - MAG_W - FRAC_BITS;

  logic               valid_q, valid_d;
  c2p_stage_t         stage_q, stage_d;
  logic signed [SQ_W-1:0]  x_sq, y_sq;
  logic signed [MAG_W-1:0] x_m, y_m;
  logic                    flip;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    x_sq = SQ_W'(x_coord_i) * SQ_W'(x_coord_i);
    y_sq = SQ_W'(y_coord_i) * SQ_W'(y_coord_i);
    flip = x_coord_i[COORD_W-1];
    // negate the point when x is negative; 17 bits hold -(-32768)
    x_m  = flip ? -MAG_W'(x_coord_i) : MAG_W'(x_coord_i);
    y_m  = flip ? -MAG_W'(y_coord_i) : MAG_W'(y_coord_i);
    stage_d.x      = {{PAD_W{x_m[MAG_W-1]}}, x_m, {FRAC_BITS{1'b0}}};
    stage_d.y      = {{PAD_W{y_m[MAG_W-1]}}, y_m, {FRAC_BITS{1'b0}}};
    if (!flip) begin
      stage_d.z = '0;
    end else if (!y_coord_i[COORD_W-1]) begin
      stage_d.z = PI_Q24;
    end else begin
      stage_d.z = -PI_Q24;
    end
    stage_d.rem    = SQ_W'(unsigned'(x_sq)) + SQ_W'(unsigned'(y_sq));
    stage_d.root   = '0;
    stage_d.origin = (x_coord_i == '0) && (y_coord_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

FILE: hdl/c2p_cell.sv
// One cell of the chain: a CORDIC vectoring step and one digit of the square root, each enabled by a parameter.
// Depends on c2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2p_cell #(
  parameter int unsigned STAGE_IDX = 0,
  parameter bit          ROTATE_EN = 1'b1,
  parameter bit          ROOT_EN   = 1'b1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire c2p_pkg::c2p_stage_t stage_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output c2p_pkg::c2p_stage_t stage_o
);
  import c2p_pkg::*;

  localparam int unsigned TAB_IDX = (STAGE_IDX < ATAN_LEN) ? STAGE_IDX : 0;
  localparam logic signed [Z_W-1:0] ANGLE_STEP =
    (STAGE_IDX < ATAN_LEN) ? ATAN_Q24[TAB_IDX] : '0;

  logic       valid_q, valid_d;
  c2p_stage_t stage_q;
  c2p_stage_t rot_d;
  c2p_stage_t root_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  if (ROTATE_EN) begin : g_rotate
    logic signed [XY_W-1:0] dx, dy;
    assign dx = stage_i.y >>> STAGE_IDX;
    assign dy = stage_i.x >>> STAGE_IDX;
    always_comb begin
      rot_d = stage_i;
      // rotate toward the x axis; y equal to zero rotates counterclockwise
      if (stage_i.y > 0) begin
        rot_d.x = stage_i.x + dx;
        rot_d.y = stage_i.y - dy;
        rot_d.z = stage_i.z + ANGLE_STEP;
      end else begin
        rot_d.x = stage_i.x - dx;
        rot_d.y = stage_i.y + dy;
        rot_d.z = stage_i.z - ANGLE_STEP;
      end
    end
  end else begin : g_no_rotate
    assign rot_d = stage_i;
  end

  if (ROOT_EN) begin : g_root
    localparam logic [SQ_W-1:0] ROOT_BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STAGE_IDX);
    logic [SQ_W-1:0] trial;
    assign trial = stage_i.root + ROOT_BIT;
    always_comb begin
      root_d = stage_i;
      if (stage_i.rem >= trial) begin
        root_d.rem  = stage_i.rem - trial;
        root_d.root = (stage_i.root >> 1) + ROOT_BIT;
      end else begin
        root_d.root = stage_i.root >> 1;
      end
    end
  end else begin : g_no_root
    assign root_d = stage_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q.x      <= rot_d.x;
      stage_q.y      <= rot_d.y;
      stage_q.z      <= rot_d.z;
      stage_q.rem    <= root_d.rem;
      stage_q.root   <= root_d.root;
      stage_q.origin <= stage_i.origin;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

FILE: hdl/c2p_out.sv
// Output register: rounds the angle accumulator and forces zero at the origin.
// Depends on c2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2p_out (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output logic                             ready_o,
  input  wire c2p_pkg::c2p_stage_t         stage_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output logic [c2p_pkg::ROOT_W-1:0]       radius_o,
  output logic signed [c2p_pkg::COORD_W-1:0] angle_o,
  output logic                             origin_point_o
);
  import c2p_pkg::*;

  localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1) << (OUT_SHIFT - 1);

  logic                       valid_q, valid_d;
  logic [ROOT_W-1:0]          radius_q;
  logic signed [COORD_W-1:0]  angle_q, angle_d;
  logic                       origin_q;
  logic signed [Z_W-1:0]      z_rnd;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    z_rnd   = stage_i.z + ROUND_HALF;
    angle_d = stage_i.origin ? '0 : z_rnd[OUT_SHIFT+COORD_W-1:OUT_SHIFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      radius_q <= stage_i.root[ROOT_W-1:0];
      angle_q  <= angle_d;
      origin_q <= stage_i.origin;
    end
  end

  assign valid_o        = valid_q;
  assign radius_o       = radius_q;
  assign angle_o        = angle_q;
  assign origin_point_o = origin_q;

endmodule

`default_nettype wire

FILE: hdl/cartesian_to_polar_converter_core.sv
// Cartesian-to-polar converter. Each request carries one signed 16-bit point
// (x, y); the result carries radius = floor(sqrt(x*x + y*y)), exact, and
// angle = atan2(y, x) in radians times 8192, rounded, plus a flag set when
// the point is the origin (angle then 0). The datapath is a chain of cells,
// each doing one CORDIC vectoring step, one digit of a restoring square
// root, or both, so a new request is taken every clock while the sink keeps
// taking results. A request passes one entry stage, one register per cell
// and one output register. Every stage holds its own valid bit, so bubbles
// collapse and requests keep entering while a finished result waits, until
// every stage of the chain is full.
// Depends on c2p_pkg, c2p_prep, c2p_cell and c2p_out.
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_polar_converter_core #(
  parameter int unsigned ROTATION_STAGES = 16  // CORDIC steps, 8..24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] x_coord, [31:16] y_coord
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [15:0] radius, [31:16] angle
  output logic             m_axis_tuser    // [0] origin_point
);
  import c2p_pkg::*;

  // The chain is as long as the longer of the two iterations
  localparam int unsigned NUM_CELLS =
    (ROTATION_STAGES > SQRT_STEPS) ? ROTATION_STAGES : SQRT_STEPS;

  // Link k feeds cell k; link NUM_CELLS feeds the output register
  logic       link_valid [NUM_CELLS+1];
  logic       link_ready [NUM_CELLS+1];
  c2p_stage_t link_stage [NUM_CELLS+1];

  logic [ROOT_W-1:0]         radius;
  logic signed [COORD_W-1:0] angle;

  c2p_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .x_coord_i (s_axis_tdata[COORD_W-1:0]),
    .y_coord_i (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .valid_o   (link_valid[0]),
    .ready_i   (link_ready[0]),
    .stage_o   (link_stage[0])
  );

  // Each cell advances its digit, its rotation or both, then hands off to its neighbor
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    c2p_cell #(
      .STAGE_IDX (g),
      .ROTATE_EN (g < ROTATION_STAGES),
      .ROOT_EN   (g < SQRT_STEPS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[g]),
      .ready_o (link_ready[g]),
      .stage_i (link_stage[g]),
      .valid_o (link_valid[g+1]),
      .ready_i (link_ready[g+1]),
      .stage_o (link_stage[g+1])
    );
  end

  // Round the angle and hold the result until the sink takes it
  c2p_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (link_valid[NUM_CELLS]),
    .ready_o        (link_ready[NUM_CELLS]),
    .stage_i        (link_stage[NUM_CELLS]),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .radius_o       (radius),
    .angle_o        (angle),
    .origin_point_o (m_axis_tuser)
  );

  assign m_axis_tdata = {angle, radius};

endmodule

`default_nettype wire

FILE: hdl/c2p_checker.sv
// Port-level checks for the cartesian-to-polar converter, bound to its top level.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module c2p_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Radius is zero exactly at the origin, and the origin has angle zero
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser == (m_axis_tdata[15:0] == 16'd0)) &&
      (!m_axis_tuser || m_axis_tdata[31:16] == 16'd0))
    else $error("origin flag disagrees with result");

  // Radius never exceeds the corner distance
  a_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'd46340)
    else $error("radius out of range");

  // Angle stays within plus or minus pi
  a_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[31:16]) <= 16'sd25736) &&
      ($signed(m_axis_tdata[31:16]) >= -16'sd25736))
    else $error("angle out of range");

  // Nothing comes out in the cycle after reset is released
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid straight out of reset");

endmodule

bind cartesian_to_polar_converter_core c2p_checker u_c2p_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: bench/cartesian_to_polar_converter_core_tb.sv
// Self-checking bench for cartesian_to_polar_converter_core: drives points
// over the request stream and checks radius, angle and origin flag per result.
// Depends on the core RTL only; the polar predictor is written locally.
`timescale 1ns / 1ps

module cartesian_to_polar_converter_core_tb;

  localparam int unsigned STAGES      = 16;
  localparam int unsigned LATENCY     = ((STAGES > 16) ? STAGES : 16) + 2;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 540;

  // Angle constants in Q24 radians
  localparam longint PI_SCALED = 52707179;
  localparam int unsigned ATAN_STEPS = 24;
  localparam longint ATAN_STEP_Q24 [ATAN_STEPS] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  typedef struct packed {
    logic [15:0]        radius;
    logic signed [15:0] angle;
    logic               origin;
  } polar_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] x_coord, [31:16] y_coord
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] radius, [31:16] angle
  logic        m_axis_tuser;   // [0] origin_point

  polar_t      expected_polar_q [$];
  int unsigned mismatch_count;
  int unsigned source_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned stall_cycles;

  cartesian_to_polar_converter_core #(
    .ROTATION_STAGES(STAGES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Exact radius by bit-serial square root; angle by pre-rotation into the
  // right half plane, then CORDIC vectoring in Q24 and round half up to Q13.
  function automatic polar_t predict_polar(input logic signed [15:0] x,
                                           input logic signed [15:0] y);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    longint          xa;
    longint          ya;
    longint          za;
    longint          dx;
    longint          dy;
    longint          ang;
    polar_t          res;
    res = '0;
    if (x == 0 && y == 0) begin
      res.origin = 1'b1;
      return res;
    end
    xa   = x;
    ya   = y;
    rem  = xa * xa + ya * ya;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    res.radius = root[15:0];

    za = 0;
    if (xa < 0) begin
      za = (ya >= 0) ? PI_SCALED : -PI_SCALED;
      xa = -xa;
      ya = -ya;
    end
    xa = xa * (64'sd1 <<< 24);
    ya = ya * (64'sd1 <<< 24);
    for (int i = 0; i < STAGES; i++) begin
      dx = ya >>> i;
      dy = xa >>> i;
      if (ya > 0) begin
        xa = xa + dx;
        ya = ya - dy;
        za = za + ((i < ATAN_STEPS) ? ATAN_STEP_Q24[i] : 0);
      end else begin
        xa = xa - dx;
        ya = ya + dy;
        za = za - ((i < ATAN_STEPS) ? ATAN_STEP_Q24[i] : 0);
      end
    end
    ang       = (za + 1024) >>> 11;
    res.angle = ang[15:0];
    return res;
  endfunction

  // Send one point; return just after the edge that accepted it.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y);
    while ($urandom_range(99) < source_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = $urandom;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_polar_q.push_back(predict_polar(x, y));
  endtask

  task automatic release_source();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_results_drained();
    while (expected_polar_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_edge_value();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return -16'sd1;
      3: return 16'sd1;
      4: return 16'sd0;
      default: return 16'sh8001;
    endcase
  endfunction

  // Origin, all four axes, the negative x axis (gives +pi), the extreme corners
  // and unit points around the origin.
  task automatic test_special_points();
    send_point(16'sd0, 16'sd0);
    send_point(16'sd1, 16'sd0);
    send_point(-16'sd1, 16'sd0);
    send_point(16'sd0, 16'sd1);
    send_point(16'sd0, -16'sd1);
    send_point(16'sd1, 16'sd1);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sh7fff, 16'sd0);
    send_point(16'sh8000, 16'sd0);
    send_point(16'sd0, 16'sh7fff);
    send_point(16'sd0, 16'sh8000);
    send_point(16'sh8000, 16'sh8000);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh7fff);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh8000, -16'sd1);
    send_point(16'sh8000, 16'sd1);
    send_point(-16'sd12345, 16'sd0);
    send_point(16'sd0, 16'sd0);
    send_point(16'sd5, -16'sd3);
    send_point(-16'sd7, 16'sd9);
    send_point(16'shffff, 16'sh8000);
    release_source();
  endtask

  // Random points: full range in four of ten draws, else small, axis, diagonal or edge values.
  task automatic test_random_points(input int unsigned count);
    logic signed [15:0] x;
    logic signed [15:0] y;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          x = $urandom;
          y = $urandom;
        end
        4, 5: begin
          x = $signed(16'($urandom_range(32))) - 16'sd16;
          y = $signed(16'($urandom_range(32))) - 16'sd16;
        end
        6: begin
          x = $urandom;
          y = $urandom_range(1) ? -x : x;
        end
        7: begin
          x = $urandom;
          y = 16'sd0;
          if ($urandom_range(1)) begin
            y = x;
            x = 16'sd0;
          end
        end
        default: begin
          x = pick_edge_value();
          y = $urandom_range(1) ? pick_edge_value() : 16'($urandom);
        end
      endcase
      send_point(x, y);
    end
    release_source();
  endtask

  // Hold off until the pipeline is empty, then push a back-to-back burst.
  task automatic test_burst_after_drain(input int unsigned count);
    int unsigned saved_pct;
    saved_pct = source_idle_pct;
    wait_results_drained();
    source_idle_pct = 0;
    test_random_points(count);
    source_idle_pct = saved_pct;
  endtask

  // Receiver backpressure, redrawn every cycle
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Compare each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    polar_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_polar_q.size() == 0) begin
        $error("unexpected result: radius %0d angle %0d origin %0b",
               m_axis_tdata[15:0], $signed(m_axis_tdata[31:16]), m_axis_tuser);
        mismatch_count++;
      end else begin
        want = expected_polar_q.pop_front();
        if (m_axis_tdata[15:0] !== want.radius) begin
          $error("radius mismatch: expected %0d, got %0d", want.radius, m_axis_tdata[15:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[31:16] !== want.angle) begin
          $error("angle mismatch: expected %0d, got %0d",
                 want.angle, $signed(m_axis_tdata[31:16]));
          mismatch_count++;
        end
        if (m_axis_tuser !== want.origin) begin
          $error("origin_point mismatch: expected %0b, got %0b", want.origin, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when neither side has moved for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    source_idle_pct = 38;
    sink_idle_pct   = 63;
    rst_ni          = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_special_points();
    test_random_points(PHASE_ITEMS);
    test_burst_after_drain(40);

    source_idle_pct = 63;
    sink_idle_pct   = 38;
    test_random_points(PHASE_ITEMS);

    source_idle_pct = 0;
    sink_idle_pct   = 0;
    test_random_points(PHASE_ITEMS);

    wait_results_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/c2p_pkg.sv
hdl/c2p_prep.sv
hdl/c2p_cell.sv
hdl/c2p_out.sv
hdl/cartesian_to_polar_converter_core.sv
hdl/c2p_checker.sv
bench/cartesian_to_polar_converter_core_tb.sv
